>>> rtl/typed_handle_allocator_macros.svh
// Assertion macros used by the allocator's checked top module.
// Each macro expects clk and rst_n in scope.
`ifndef TYPED_HANDLE_ALLOCATOR_MACROS_SVH
`define TYPED_HANDLE_ALLOCATOR_MACROS_SVH

// Check cons in the same cycle as ante.
`define THA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define THA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tha_pkg.sv
package tha_pkg;

    // Fixed field widths of the channels
    localparam int ID_W       = 9;
    localparam int STATUS_W   = 2;
    localparam int RUN_W      = 7;
    localparam int TYPE_IN_W  = 4;
    localparam int TYPE_MAX_W = 8;

    // Default sizing
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_RUN_DEF     = 64;
    localparam int TYPE_BITS_DEF   = 4;

    // Tag of a free slot
    localparam logic [TYPE_MAX_W-1:0] TYPE_NONE = '0;

    typedef enum logic [1:0] {
        OP_GENERATE = 2'd0,
        OP_DELETE   = 2'd1,
        OP_QUERY    = 2'd2,
        OP_CLAIM    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_BADID   = 2'd3
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    clr_wr;
        logic    scan_start;
        logic    scan_step;
        logic    lookup_rd;
        logic    claim_wr;
        logic    del_wr;
        logic    append;
        logic    emit_run;
        logic    out_reply;
        status_t reply_status;
        logic    reply_present;
    } tha_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic clr_done;
        logic n_zero;
        logic n_big;
        logic type_zero;
        logic id_zero;
        logic id_over;
        logic used_zero;
        logic match;
        logic found;
        logic scan_done;
        logic no_room;
        logic run_last;
        logic out_free;
    } tha_stat_t;

endpackage

>>> rtl/typed_handle_allocator.sv
// Typed handle allocator: a table of type tags (tag 0 = free) with 1-based handles.
// Input channel (in_valid / in_stall) carries operation, object_type, run_length and
// object_id; a transfer happens when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall) carries granted_id, status, is_present, last;
// every item yields one or more results, the final one marked by last.
// One item is in work at a time; in_stall is low only while the block is idle.
// Delete, query and claim: after the decode state the result is loaded once the output is free.
// Generate: the first-fit scan reads one slot per cycle from the single read port of
// the tag memory; then one result per cycle follows while out_stall is low, run_length
// results in all.
// Reset: after rst_n rises, a clearing pass writes every slot free, one per cycle, with
// in_stall high; results never appear during it.
// Stall: a result holds in the output register while out_stall is high, and the run
// under way pauses until it is taken; the next input can be taken while the last
// result of the previous item still waits.
`include "typed_handle_allocator_macros.svh"

module typed_handle_allocator import tha_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_RUN     = MAX_RUN_DEF,
    parameter int TYPE_BITS   = TYPE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           operation,
    input  logic [TYPE_IN_W-1:0] object_type,
    input  logic [RUN_W-1:0]     run_length,
    input  logic [ID_W-1:0]      object_id,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ID_W-1:0]      granted_id,
    output logic [STATUS_W-1:0]  status,
    output logic                 is_present,
    output logic                 last
);

    tha_cmd_t  cmd;
    tha_stat_t stat;

    tha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tha_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_RUN     (MAX_RUN),
        .TYPE_BITS   (TYPE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .object_type (object_type),
        .run_length  (run_length),
        .object_id   (object_id),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .granted_id  (granted_id),
        .status      (status),
        .is_present  (is_present),
        .last        (last),
        .cmd         (cmd),
        .stat        (stat)
    );

    // No result while the table is being cleared
    `THA_ASSERT_NOW(a_no_out_in_clear, cmd.clr_wr, !out_valid, "result during clear")
    // An accepted item blocks further input
    `THA_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input not held off")
    // A run keeps results coming until its last one
    `THA_ASSERT_NEXT(a_run_continues, out_valid && !last, out_valid, "run broke off")
    // A granted handle always comes with status ok
    `THA_ASSERT_NOW(a_grant_ok, out_valid && (granted_id != '0), status == ST_OK, "grant not ok")

endmodule

>>> rtl/tha_ram.sv
module tha_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tha_ctrl.sv
module tha_ctrl import tha_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  tha_stat_t stat,
    output tha_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_LOOKUP,
        S_EMIT,
        S_REPLY
    } state_t;

    state_t  state_reg, state_next;
    status_t reply_reg, reply_next;

    // Sequence one item at a time
    always_comb
    begin
        cmd              = '0;
        cmd.reply_status = reply_reg;
        state_next       = state_reg;
        reply_next       = reply_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_GENERATE:
                    begin
                        priority if (stat.n_zero)
                        begin
                            reply_next = ST_OK;
                            state_next = S_REPLY;
                        end
                        else if (stat.type_zero)
                        begin
                            reply_next = ST_BADID;
                            state_next = S_REPLY;
                        end
                        else if (stat.n_big)
                        begin
                            reply_next = ST_NOSPACE;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (stat.used_zero)
                        begin
                            reply_next = ST_INVALID;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            cmd.lookup_rd = 1'b1;
                            state_next    = S_LOOKUP;
                        end
                    end
                    OP_QUERY:
                    begin
                        cmd.lookup_rd = 1'b1;
                        state_next    = S_LOOKUP;
                    end
                    OP_CLAIM:
                    begin
                        priority if (stat.id_zero || stat.type_zero)
                        begin
                            reply_next = ST_BADID;
                        end
                        else if (stat.id_over)
                        begin
                            reply_next = ST_NOSPACE;
                        end
                        else
                        begin
                            cmd.claim_wr = 1'b1;
                            reply_next   = ST_OK;
                        end
                        state_next = S_REPLY;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                priority if (stat.found)
                begin
                    state_next = S_EMIT;
                end
                else if (stat.scan_done)
                begin
                    if (stat.no_room)
                    begin
                        reply_next = ST_NOSPACE;
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end
            S_LOOKUP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_reply     = 1'b1;
                    cmd.reply_status  = ST_OK;
                    cmd.reply_present = (stat.op == OP_QUERY) && stat.match;
                    cmd.del_wr        = (stat.op == OP_DELETE) && stat.match;
                    state_next        = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_run = 1'b1;
                    if (stat.run_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.out_reply = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the pending reply code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            reply_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

>>> rtl/tha_dp.sv
module tha_dp import tha_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_RUN     = MAX_RUN_DEF,
    parameter int TYPE_BITS   = TYPE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           operation,
    input  logic [TYPE_IN_W-1:0] object_type,
    input  logic [RUN_W-1:0]     run_length,
    input  logic [ID_W-1:0]      object_id,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [ID_W-1:0]      granted_id,
    output logic [STATUS_W-1:0]  status,
    output logic                 is_present,
    output logic                 last,
    input  tha_cmd_t             cmd,
    output tha_stat_t            stat
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int UW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = ((UW > ID_W) ? UW : ID_W) + 1;

    // Latched item
    op_t                  op_reg;
    logic [TYPE_BITS-1:0] type_reg;
    logic [RUN_W-1:0]     n_reg;
    logic [ID_W-1:0]      id_reg;

    // Table bookkeeping and scan counters
    logic [UW-1:0]    used_reg, used_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [UW-1:0]    scan_reg, scan_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [UW-1:0]    cur_reg, cur_next;
    logic [RUN_W-1:0] k_reg, k_next;

    // Output register
    logic            out_valid_reg, out_valid_next;
    logic [ID_W-1:0] granted_reg, granted_next;
    status_t         status_reg, status_next;
    logic            present_reg, present_next;
    logic            last_reg, last_next;
    logic            out_load;

    logic [TYPE_MAX_W-1:0] type_ext;
    logic [XW-1:0]         used_x, id_x, n_x, scan_x, cur_x, depth_x;
    logic [XW-1:0]         id_m1_x, sum_x, base_x, gid_x;
    logic [AW-1:0]         id_addr;
    logic                  scan_issue, slot_free, id_in_used;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [TYPE_BITS-1:0] ram_wdata, rd_data;

    assign type_ext = TYPE_MAX_W'(object_type);

    // Common-width views for compare, add and subtract
    assign used_x  = XW'(used_reg);
    assign id_x    = XW'(id_reg);
    assign n_x     = XW'(n_reg);
    assign scan_x  = XW'(scan_reg);
    assign cur_x   = XW'(cur_reg);
    assign depth_x = XW'(TABLE_DEPTH);
    assign id_m1_x = id_x - XW'(1);
    assign id_addr = id_m1_x[AW-1:0];
    assign sum_x   = used_x + n_x;
    assign base_x  = scan_x - n_x;
    assign gid_x   = cur_x + XW'(1);

    assign scan_issue = (scan_x < used_x);
    assign slot_free  = (rd_data == TYPE_NONE[TYPE_BITS-1:0]);
    assign id_in_used = (id_reg != '0) && (id_x <= used_x);
    assign out_load   = cmd.emit_run || cmd.out_reply;

    // Status toward the controller
    always_comb
    begin
        stat           = '0;
        stat.op        = op_reg;
        stat.clr_done  = (clr_reg == AW'(TABLE_DEPTH - 1));
        stat.n_zero    = (n_reg == '0);
        stat.n_big     = (n_reg > RUN_W'(MAX_RUN));
        stat.type_zero = (type_reg == TYPE_NONE[TYPE_BITS-1:0]);
        stat.id_zero   = (id_reg == '0);
        stat.id_over   = (id_x > depth_x);
        stat.used_zero = (used_reg == '0);
        stat.match     = id_in_used && (rd_data == type_reg);
        stat.found     = rd_pend_reg && slot_free && ((run_reg + RUN_W'(1)) == n_reg);
        stat.scan_done = !rd_pend_reg && !scan_issue;
        stat.no_room   = (sum_x > depth_x);
        stat.run_last  = ((k_reg + RUN_W'(1)) == n_reg);
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    // Select the single write of this cycle
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = id_addr;
        ram_wdata = type_reg;
        if (cmd.clr_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (cmd.claim_wr)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.del_wr)
        begin
            ram_we    = 1'b1;
            ram_wdata = '0;
        end
        else if (cmd.emit_run)
        begin
            ram_we    = 1'b1;
            ram_waddr = cur_reg[AW-1:0];
        end
    end

    // Read the scan slot or the looked-up handle
    assign ram_re    = (cmd.scan_step && scan_issue) || cmd.lookup_rd;
    assign ram_raddr = cmd.lookup_rd ? id_addr : scan_reg[AW-1:0];

    tha_ram #(
        .WIDTH (TYPE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // Advance counters, grow the used part, load results
    always_comb
    begin
        used_next      = used_reg;
        clr_next       = clr_reg;
        scan_next      = scan_reg;
        rd_pend_next   = rd_pend_reg;
        run_next       = run_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        present_next   = present_reg;
        last_next      = last_reg;

        if (cmd.clr_wr)
        begin
            clr_next = clr_reg + AW'(1);
        end
        if (cmd.scan_start)
        begin
            scan_next    = '0;
            run_next     = '0;
            rd_pend_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            if (scan_issue)
            begin
                scan_next = scan_reg + UW'(1);
            end
            rd_pend_next = scan_issue;
            if (rd_pend_reg)
            begin
                run_next = slot_free ? (run_reg + RUN_W'(1)) : '0;
            end
            if (stat.found)
            begin
                cur_next = base_x[UW-1:0];
                k_next   = '0;
            end
        end
        if (cmd.append)
        begin
            cur_next  = used_reg;
            k_next    = '0;
            used_next = sum_x[UW-1:0];
        end
        if (cmd.claim_wr && (id_x > used_x))
        begin
            used_next = id_x[UW-1:0];
        end
        if (cmd.emit_run)
        begin
            cur_next     = cur_reg + UW'(1);
            k_next       = k_reg + RUN_W'(1);
            granted_next = gid_x[ID_W-1:0];
            status_next  = ST_OK;
            present_next = 1'b0;
            last_next    = stat.run_last;
        end
        if (cmd.out_reply)
        begin
            granted_next = '0;
            status_next  = cmd.reply_status;
            present_next = cmd.reply_present;
            last_next    = 1'b1;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            clr_reg       <= '0;
            scan_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            run_reg       <= '0;
            cur_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            clr_reg       <= clr_next;
            scan_reg      <= scan_next;
            rd_pend_reg   <= rd_pend_next;
            run_reg       <= run_next;
            cur_reg       <= cur_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(operation);
            type_reg <= type_ext[TYPE_BITS-1:0];
            n_reg    <= run_length;
            id_reg   <= object_id;
        end
        granted_reg <= granted_next;
        status_reg  <= status_next;
        present_reg <= present_next;
        last_reg    <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign granted_id = granted_reg;
    assign status     = status_reg;
    assign is_present = present_reg;
    assign last       = last_reg;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tha_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_500_000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          RANDOM_CMDS  = 200;
    localparam logic [3:0]  FREE_TAG     = TYPE_NONE[TYPE_IN_W-1:0];

    // One command to the allocator; typed rows carry their own reply
    typedef struct {
        op_t                  op;
        logic [TYPE_IN_W-1:0] tag;
        logic [RUN_W-1:0]     count;
        logic [ID_W-1:0]      handle;
        bit                   typed;
        status_t              want_status;
        logic                 want_present;
    } command_t;

    // One reply from the allocator
    typedef struct {
        logic [ID_W-1:0] handle;
        status_t         code;
        logic            present;
        logic            fin;
    } reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           operation = '0;
    logic [TYPE_IN_W-1:0] object_type = '0;
    logic [RUN_W-1:0]     run_length = '0;
    logic [ID_W-1:0]      object_id = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ID_W-1:0]      granted_id;
    logic [STATUS_W-1:0]  status;
    logic                 is_present;
    logic                 last;

    // Shadow of the tag table and its used size
    logic [TYPE_IN_W-1:0] tag_shadow [TABLE_DEPTH_DEF];
    int unsigned          used_shadow = 0;

    reply_t      owed_replies [$];
    command_t    directed_cmds [$];
    int unsigned mismatch_cnt = 0;
    int unsigned cmds_sent = 0;
    int unsigned replies_seen = 0;
    int unsigned handles_granted = 0;
    int unsigned nospace_seen = 0;
    int unsigned cycle_cnt = 0;
    int unsigned stall_hold = 0;
    bit          calm = 1'b0;

    typed_handle_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .object_type (object_type),
        .run_length  (run_length),
        .object_id   (object_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .granted_id  (granted_id),
        .status      (status),
        .is_present  (is_present),
        .last        (last)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 24);
    endfunction

    function automatic reply_t single_reply(status_t code, logic present);
        reply_t r;
        r.handle  = '0;
        r.code    = code;
        r.present = present;
        r.fin     = 1'b1;
        return r;
    endfunction

    // Apply one command to the shadow table and list the replies it owes
    function automatic void apply_handle_op(command_t c, ref reply_t replies[$]);
        int unsigned base;
        int unsigned i;
        int unsigned j;
        int unsigned n;
        int unsigned id;
        bit          found;
        reply_t      r;
        replies.delete();
        n  = c.count;
        id = c.handle;
        case (c.op)
            OP_GENERATE:
            begin
                if (n == 0)
                    replies.push_back(single_reply(ST_OK, 1'b0));
                else if (c.tag == FREE_TAG)
                    replies.push_back(single_reply(ST_BADID, 1'b0));
                else if (n > MAX_RUN_DEF)
                    replies.push_back(single_reply(ST_NOSPACE, 1'b0));
                else
                begin
                    // first-fit search over the used part
                    found = 1'b0;
                    base  = 0;
                    i     = 0;
                    while (!found && i + n <= used_shadow)
                    begin
                        j = 0;
                        while (j < n && tag_shadow[i + j] == FREE_TAG)
                            j++;
                        if (j == n)
                        begin
                            found = 1'b1;
                            base  = i;
                        end
                        else
                            i = i + j + 1;
                    end
                    if (!found && used_shadow + n > TABLE_DEPTH_DEF)
                        replies.push_back(single_reply(ST_NOSPACE, 1'b0));
                    else
                    begin
                        // grow the table when no hole fits
                        if (!found)
                        begin
                            base        = used_shadow;
                            used_shadow = used_shadow + n;
                        end
                        for (j = 0; j < n; j++)
                        begin
                            tag_shadow[base + j] = c.tag;
                            r.handle  = ID_W'(base + j + 1);
                            r.code    = ST_OK;
                            r.present = 1'b0;
                            r.fin     = (j + 1 == n);
                            replies.push_back(r);
                        end
                    end
                end
            end
            OP_DELETE:
            begin
                if (used_shadow == 0)
                    replies.push_back(single_reply(ST_INVALID, 1'b0));
                else
                begin
                    if (id != 0 && id <= used_shadow && tag_shadow[id - 1] == c.tag)
                        tag_shadow[id - 1] = FREE_TAG;
                    replies.push_back(single_reply(ST_OK, 1'b0));
                end
            end
            OP_QUERY:
            begin
                replies.push_back(single_reply(ST_OK,
                    id != 0 && id <= used_shadow && tag_shadow[id - 1] == c.tag));
            end
            default:
            begin
                if (id == 0 || c.tag == FREE_TAG)
                    replies.push_back(single_reply(ST_BADID, 1'b0));
                else if (id > TABLE_DEPTH_DEF)
                    replies.push_back(single_reply(ST_NOSPACE, 1'b0));
                else
                begin
                    if (id > used_shadow)
                        used_shadow = id;
                    tag_shadow[id - 1] = c.tag;
                    replies.push_back(single_reply(ST_OK, 1'b0));
                end
            end
        endcase
    endfunction

    task automatic add_row(op_t op, logic [3:0] tag, logic [6:0] count, logic [8:0] handle,
                           bit typed = 1'b0, status_t code = ST_OK, logic present = 1'b0);
        command_t c;
        c.op           = op;
        c.tag          = tag;
        c.count        = count;
        c.handle       = handle;
        c.typed        = typed;
        c.want_status  = code;
        c.want_present = present;
        directed_cmds.push_back(c);
    endtask

    // Random command; deletes and queries are mostly aimed at live handles of the shadow table
    function automatic command_t random_cmd();
        command_t    c;
        int unsigned pick;
        int unsigned r;
        int unsigned top;
        pick          = $urandom_range(0, 99);
        c.typed       = 1'b0;
        c.want_status = ST_OK;
        c.want_present = 1'b0;
        c.op          = OP_GENERATE;
        c.tag         = 4'($urandom_range(1, 15));
        c.count       = '0;
        c.handle      = '0;
        if (pick < 38)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                c.count = 7'($urandom_range(1, 8));
            else if (r < 92)
                c.count = 7'($urandom_range(9, 64));
            else if (r < 96)
                c.count = '0;
            else
                c.count = 7'($urandom_range(65, 127));
            if ($urandom_range(0, 19) == 0)
                c.tag = FREE_TAG;
        end
        else if (pick < 80)
        begin
            c.op = (pick < 63) ? OP_DELETE : OP_QUERY;
            if (used_shadow != 0 && $urandom_range(0, 9) < 8)
            begin
                c.handle = 9'($urandom_range(1, used_shadow));
                if ($urandom_range(0, 9) < 8)
                    c.tag = tag_shadow[c.handle - 1];
            end
            else
                c.handle = 9'($urandom);
        end
        else if (pick < 90)
        begin
            c.op = OP_CLAIM;
            top  = (used_shadow + 8 > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : used_shadow + 8;
            if ($urandom_range(0, 9) < 8)
                c.handle = 9'($urandom_range(1, top));
            else
            begin
                c.handle = 9'($urandom);
                c.tag    = 4'($urandom);
            end
        end
        else
        begin
            // noise: every field at full width
            c.op     = op_t'($urandom_range(0, 3));
            c.tag    = 4'($urandom);
            c.count  = 7'($urandom);
            c.handle = 9'($urandom);
        end
        return c;
    endfunction

    // Drive one command, hold it until the transfer, then log what it owes
    task automatic send_cmd(command_t c);
        int unsigned gap;
        reply_t      calc [$];
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= c.op;
        object_type <= c.tag;
        run_length  <= c.count;
        object_id   <= c.handle;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_handle_op(c, calc);
        if (c.typed)
            owed_replies.push_back(single_reply(c.want_status, c.want_present));
        else
            foreach (calc[k])
                owed_replies.push_back(calc[k]);
        cmds_sent++;
        calm = ((cmds_sent / 30) % 4) == 3;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatch_cnt++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Stall the reply side in random bursts
    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            out_stall  <= !calm && !out_stall && ($urandom_range(0, 2) == 0);
            stall_hold <= pick_gap();
        end
    end

    // Check each reply transfer against the oldest owed reply
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            replies_seen++;
            if (status == ST_NOSPACE)
                nospace_seen++;
            if (status == ST_OK && granted_id != 0)
                handles_granted++;
            if (owed_replies.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected reply: expected none, actual id %0d status %0d",
                         $time, granted_id, status);
            end
            else
            begin
                want = owed_replies.pop_front();
                check_field("granted_id", want.handle, granted_id);
                check_field("status", want.code, status);
                check_field("is_present", want.present, is_present);
                check_field("last", want.fin, last);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d replies outstanding", $time, owed_replies.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        foreach (tag_shadow[k])
            tag_shadow[k] = FREE_TAG;

        // Directed rows: empty-table cases and error codes first
        add_row(OP_QUERY,    1,   0,   1, 1'b1, ST_OK,      1'b0);
        add_row(OP_DELETE,   1,   0,   1, 1'b1, ST_INVALID, 1'b0);
        add_row(OP_GENERATE, 5,   0,   0, 1'b1, ST_OK,      1'b0);
        add_row(OP_GENERATE, 1,  65,   0, 1'b1, ST_NOSPACE, 1'b0);
        add_row(OP_GENERATE, 15, 127, 511, 1'b1, ST_NOSPACE, 1'b0);
        add_row(OP_GENERATE, 0,   4,   0, 1'b1, ST_BADID,   1'b0);
        add_row(OP_CLAIM,    3,   0,   0, 1'b1, ST_BADID,   1'b0);
        add_row(OP_CLAIM,    3,   0, 257, 1'b1, ST_NOSPACE, 1'b0);
        add_row(OP_CLAIM,    15, 127, 511, 1'b1, ST_NOSPACE, 1'b0);
        add_row(OP_CLAIM,    0,   0,   5, 1'b1, ST_BADID,   1'b0);
        add_row(OP_DELETE,   2,   0,   3, 1'b1, ST_INVALID, 1'b0);
        // Allocation, type matching, free-slot query, growth by claim
        add_row(OP_GENERATE, 1,   1,   0);
        add_row(OP_GENERATE, 15, 64,   0);
        add_row(OP_QUERY,    1,   0,   1);
        add_row(OP_QUERY,    15,  0,  65);
        add_row(OP_DELETE,   2,   0,   1);
        add_row(OP_DELETE,   1,   0,   1);
        add_row(OP_QUERY,    0,   0,   1);
        add_row(OP_DELETE,   0,   0,   1);
        add_row(OP_DELETE,   15,  0,   0);
        add_row(OP_CLAIM,    7,   0, 256);
        add_row(OP_QUERY,    7,   0, 256);
        add_row(OP_GENERATE, 2,   1,   0);
        add_row(OP_GENERATE, 4,  64,   0);
        add_row(OP_DELETE,   4,   0, 300);
        add_row(OP_QUERY,    15,  0, 511);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cmds[k])
            send_cmd(directed_cmds[k]);
        repeat (RANDOM_CMDS)
            send_cmd(random_cmd());
        in_valid <= 1'b0;

        // Drain, then watch for stray replies
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands, checked %0d replies, %0d handles granted.",
                 cmds_sent, replies_seen, handles_granted);
        $display("Saw %0d out-of-space replies; table grew to %0d slots.",
                 nospace_seen, used_shadow);
        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tha_pkg.sv
rtl/tha_ram.sv
rtl/tha_ctrl.sv
rtl/tha_dp.sv
rtl/typed_handle_allocator.sv
dv/testbench.sv
